// File: rtl/llf_pkg.sv
// Shared types, codes and the prefix table of the line and length deframer.
`default_nettype none
package llf_pkg;

    localparam logic [7:0] NEWLINE     = 8'h0A;
    localparam logic [2:0] PREFIX_LAST = 3'd4;   // index of the final prefix character
    localparam int         QUEUE_DEPTH = 4;
    localparam int         QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_FILE = 1'b1;

    // One classified input byte: a flush of held prefix characters and/or one
    // single result.
    typedef struct packed {
        logic [2:0] flush_cnt;
        logic       flush_last;
        logic       single_vld;
        logic [7:0] data;
        logic       has_byte;
        logic       is_last;
        logic       kind;
    } t_action;

    // Characters of the header prefix "POST ".
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h50;  // P
            3'd1:    ch = 8'h4F;  // O
            3'd2:    ch = 8'h53;  // S
            3'd3:    ch = 8'h54;  // T
            3'd4:    ch = 8'h20;  // space
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// File: rtl/llf_if.sv
// Valid/ready channel interfaces for the deframer input bytes and result items.
`default_nettype none
interface llf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface llf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       is_last;
    logic       message_kind;

    modport source (output valid, output out_byte, output has_byte, output is_last,
                    output message_kind, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input is_last,
                    input message_kind, output ready);
endinterface
`default_nettype wire

// File: rtl/line_and_length_deframer_top.sv
// Text bytes are held one byte back so the final byte of a line can carry is_last;
// results pass through the action queue and then the back end's output register.
// Throughput: one byte per cycle unless the queue is full; a failed prefix match flushes
// up to four held characters, one result item per cycle from the output register while the sink is ready.
// Reset (synchronous, active low) returns to line start and empties the queue.
`default_nettype none
module line_and_length_deframer_top #(
    parameter int LENGTH_BITS = 20
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    llf_in_if.sink      i_in,
    llf_out_if.source   o_out
);
    import llf_pkg::*;

    logic    push, pop, full, empty;
    t_action action, head;

    // Front end: classify each byte, update framing state, issue an action.
    llf_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_byte   (i_in.byte_in),
        .i_full   (full),
        .o_ready  (i_in.ready),
        .o_push   (push),
        .o_action (action)
    );

    // Decouple parsing from result delivery so each side stalls on its own.
    llf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (action),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // Back end: expand each action into one or more result items.
    llf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .i_out_ready    (o_out.ready),
        .o_pop          (pop),
        .o_valid        (o_out.valid),
        .o_out_byte     (o_out.out_byte),
        .o_has_byte     (o_out.has_byte),
        .o_is_last      (o_out.is_last),
        .o_message_kind (o_out.message_kind)
    );

endmodule
`default_nettype wire

// File: rtl/llf_front.sv
// Front end: parses each byte, tracks framing state and issues actions.
`default_nettype none
module llf_front #(
    parameter int LENGTH_BITS = 20
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_full,
    output logic                 o_ready,
    output logic                 o_push,
    output llf_pkg::t_action     o_action
);
    import llf_pkg::*;

    typedef enum logic [1:0] {
        MODE_START,
        MODE_TEXT,
        MODE_HEADER,
        MODE_PAYLOAD
    } t_mode;

    localparam logic [LENGTH_BITS-1:0]   LEN_MAX  = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS+3:0]   WIDE_MAX = {4'b0000, LEN_MAX};

    t_mode                  r_mode, n_mode;
    logic [2:0]             r_matched, n_matched;
    logic [LENGTH_BITS-1:0] r_accum, n_accum;
    logic                   r_ended, n_ended;
    logic [LENGTH_BITS-1:0] r_left, n_left;
    logic [7:0]             r_held, n_held;

    logic                   accept;
    logic                   is_nl;
    logic                   is_digit;
    logic [LENGTH_BITS+3:0] wide;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign is_nl    = (i_byte == NEWLINE);
    assign is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    // accum * 10 + digit, four bits wider headroom for saturation
    assign wide = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                + {{(LENGTH_BITS){1'b0}}, i_byte[3:0]};

    always_comb begin
        n_mode    = r_mode;
        n_matched = r_matched;
        n_accum   = r_accum;
        n_ended   = r_ended;
        n_left    = r_left;
        n_held    = r_held;
        o_push    = 1'b0;
        o_action  = '0;
        case (r_mode)
            MODE_START: begin
                if (i_byte == prefix_char(r_matched)) begin
                    if (r_matched == PREFIX_LAST) begin
                        n_matched = '0;
                        n_accum   = '0;
                        n_ended   = 1'b0;
                        n_mode    = MODE_HEADER;
                    end else begin
                        n_matched = r_matched + 3'd1;
                    end
                end else if (is_nl) begin
                    o_push = 1'b1;
                    if (r_matched == 3'd0) begin
                        o_action.single_vld = 1'b1;
                        o_action.is_last    = 1'b1;
                        o_action.kind       = KIND_TEXT;
                    end else begin
                        o_action.flush_cnt  = r_matched;
                        o_action.flush_last = 1'b1;
                    end
                    n_matched = '0;
                end else begin
                    o_push             = (r_matched != 3'd0);
                    o_action.flush_cnt = r_matched;
                    n_matched          = '0;
                    n_held             = i_byte;
                    n_mode             = MODE_TEXT;
                end
            end
            MODE_TEXT: begin
                o_push              = 1'b1;
                o_action.single_vld = 1'b1;
                o_action.data       = r_held;
                o_action.has_byte   = 1'b1;
                o_action.is_last    = is_nl;
                o_action.kind       = KIND_TEXT;
                if (is_nl) begin
                    n_mode = MODE_START;
                end else begin
                    n_held = i_byte;
                end
            end
            MODE_HEADER: begin
                if (is_nl) begin
                    if (r_accum == '0) begin
                        o_push              = 1'b1;
                        o_action.single_vld = 1'b1;
                        o_action.is_last    = 1'b1;
                        o_action.kind       = KIND_FILE;
                        n_mode              = MODE_START;
                    end else begin
                        n_left = r_accum;
                        n_mode = MODE_PAYLOAD;
                    end
                    n_accum = '0;
                    n_ended = 1'b0;
                end else if (!r_ended && is_digit) begin
                    n_accum = (wide > WIDE_MAX) ? LEN_MAX : wide[LENGTH_BITS-1:0];
                end else begin
                    n_ended = 1'b1;
                end
            end
            MODE_PAYLOAD: begin
                o_push              = 1'b1;
                o_action.single_vld = 1'b1;
                o_action.data       = i_byte;
                o_action.has_byte   = 1'b1;
                o_action.kind       = KIND_FILE;
                if (r_left <= {{(LENGTH_BITS-1){1'b0}}, 1'b1}) begin
                    o_action.is_last = 1'b1;
                    n_left           = '0;
                    n_mode           = MODE_START;
                end else begin
                    n_left = r_left - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                end
            end
            default: begin
                n_mode = MODE_START;
            end
        endcase
        if (!accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_START;
            r_matched <= '0;
            r_accum   <= '0;
            r_ended   <= 1'b0;
            r_left    <= '0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_matched <= n_matched;
            r_accum   <= n_accum;
            r_ended   <= n_ended;
            r_left    <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule
`default_nettype wire

// File: rtl/llf_queue.sv
// Short action queue between the front end and the back end.
`default_nettype none
module llf_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  llf_pkg::t_action      i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output llf_pkg::t_action      o_head
);
    import llf_pkg::*;

    t_action              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr, r_rd;
    logic [QUEUE_AW:0]    r_cnt;

    assign o_full  = (r_cnt == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QUEUE_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QUEUE_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/llf_back.sv
// Back end: expands queued actions into result items behind an output register.
`default_nettype none
module llf_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  llf_pkg::t_action      i_head,
    input  wire logic             i_out_ready,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [7:0]            o_out_byte,
    output logic                  o_has_byte,
    output logic                  o_is_last,
    output logic                  o_message_kind
);
    import llf_pkg::*;

    logic [2:0] r_idx;
    logic       r_vld;
    logic [7:0] r_data;
    logic       r_has, r_last, r_kind;

    logic       load;
    logic       done;
    logic       at_end;
    logic [7:0] n_data;
    logic       n_has, n_last, n_kind;

    assign load   = !i_empty && (!r_vld || i_out_ready);
    assign at_end = (r_idx + 3'd1 == i_head.flush_cnt);

    always_comb begin
        if (r_idx < i_head.flush_cnt) begin
            n_data = prefix_char(r_idx);
            n_has  = 1'b1;
            n_last = i_head.flush_last && at_end;
            n_kind = KIND_TEXT;
            done   = at_end && !i_head.single_vld;
        end else begin
            n_data = i_head.data;
            n_has  = i_head.has_byte;
            n_last = i_head.is_last;
            n_kind = i_head.kind;
            done   = 1'b1;
        end
    end

    assign o_pop = load && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (load) begin
            r_vld <= 1'b1;
            r_idx <= done ? 3'd0 : r_idx + 3'd1;
        end else if (i_out_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
            r_has  <= n_has;
            r_last <= n_last;
            r_kind <= n_kind;
        end
    end

    assign o_valid        = r_vld;
    assign o_out_byte     = r_data;
    assign o_has_byte     = r_has;
    assign o_is_last      = r_last;
    assign o_message_kind = r_kind;

endmodule
`default_nettype wire
